[src/mbrm_pkg.sv]
// Shared types, codes and the CRC-16/Modbus byte update for the Modbus read master.
package mbrm_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_ATTEMPTS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd3;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] REPLY_BYTE_COUNT = 8'h02;
  localparam logic [15:0] QUANTITY_ONE = 16'h0001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave;
    logic [15:0] register_addr;
    logic [15:0] data;
  } desc_t;

  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/mbrm_if.sv]
// Stream interfaces for command beats in and result beats out.
interface mbrm_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [7:0] slave_address;
  logic [15:0] register_address;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, slave_address, register_address, rx_byte,
                  input ready);
  modport sink (input valid, opcode, slave_address, register_address, rx_byte,
                output ready);
endinterface

interface mbrm_res_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic [15:0] reading;
  logic last;

  modport source (output valid, kind, tx_byte, reading, last, input ready);
  modport sink (input valid, kind, tx_byte, reading, last, output ready);
endinterface

[src/mbrm_core.sv]
// Transaction state machine: reply checking, timeout, attempt count, result descriptors.
module mbrm_core (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [1:0] opcode,
  input  logic [7:0] slave_address,
  input  logic [15:0] register_address,
  input  logic [7:0] rx_byte,
  input  logic [15:0] timeout_ticks,
  input  logic [3:0] max_attempts,
  output logic desc_wr,
  output mbrm_pkg::desc_t desc
);
  import mbrm_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_FUNC = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_DATA_HI = 3'd4;
  localparam logic [2:0] PH_DATA_LO = 3'd5;
  localparam logic [2:0] PH_CRC_LO = 3'd6;
  localparam logic [2:0] PH_CRC_HI = 3'd7;

  logic [2:0] phase, phase_next;
  logic [3:0] attempts_used, attempts_used_next;
  logic [15:0] silence_timer, silence_timer_next;
  logic [15:0] reply_crc, reply_crc_next;
  logic [15:0] reply_data, reply_data_next;
  logic [7:0] crc_low_byte, crc_low_byte_next;
  logic [7:0] target_slave, target_slave_next;
  logic [15:0] target_register, target_register_next;

  logic busy;
  logic retry;
  logic ok;
  logic [15:0] tick_count;
  logic [3:0] att;

  assign busy = (phase != PH_IDLE);

  always_comb begin
    phase_next = phase;
    attempts_used_next = attempts_used;
    silence_timer_next = silence_timer;
    reply_crc_next = reply_crc;
    reply_data_next = reply_data;
    crc_low_byte_next = crc_low_byte;
    target_slave_next = target_slave;
    target_register_next = target_register;
    desc_wr = 1'b0;
    desc = '0;
    retry = 1'b0;
    ok = 1'b1;
    tick_count = silence_timer;
    att = attempts_used;

    if (accept) begin
      case (opcode)
        OP_START: begin
          target_slave_next = slave_address;
          target_register_next = register_address;
          att = 4'd0;
          retry = 1'b1;
        end
        OP_BYTE: begin
          if (busy) begin
            silence_timer_next = '0;
            case (phase)
              PH_ADDR: ok = (rx_byte == target_slave);
              PH_FUNC: ok = (rx_byte == FUNC_READ_HOLDING);
              PH_COUNT: ok = (rx_byte == REPLY_BYTE_COUNT);
              PH_DATA_HI: reply_data_next = {rx_byte, 8'h00};
              PH_DATA_LO: reply_data_next = {reply_data[15:8], rx_byte};
              PH_CRC_LO: crc_low_byte_next = rx_byte;
              default: ok = 1'b1;
            endcase
            if (!ok) begin
              retry = 1'b1;
            end else if (phase == PH_CRC_HI) begin
              if ({rx_byte, crc_low_byte} == reply_crc) begin
                phase_next = PH_IDLE;
                desc_wr = 1'b1;
                desc.kind = KIND_OK;
                desc.data = reply_data;
              end else begin
                retry = 1'b1;
              end
            end else begin
              if (phase <= PH_DATA_LO) begin
                reply_crc_next = crc16_add(reply_crc, rx_byte);
              end
              phase_next = phase + 3'd1;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            if (silence_timer != 16'hFFFF) begin
              tick_count = silence_timer + 16'd1;
            end
            silence_timer_next = tick_count;
            if (tick_count >= timeout_ticks) begin
              retry = 1'b1;
            end
          end
        end
        default: retry = 1'b0;
      endcase
    end

    if (retry) begin
      attempts_used_next = att;
      silence_timer_next = '0;
      desc_wr = 1'b1;
      if (att >= max_attempts) begin
        phase_next = PH_IDLE;
        desc.kind = KIND_FAIL;
      end else begin
        attempts_used_next = att + 4'd1;
        phase_next = PH_ADDR;
        reply_crc_next = CRC_INIT;
        reply_data_next = '0;
        crc_low_byte_next = '0;
        desc.kind = KIND_TX;
        desc.slave = target_slave_next;
        desc.register_addr = target_register_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      attempts_used <= '0;
      silence_timer <= '0;
      reply_crc <= CRC_INIT;
      reply_data <= '0;
      crc_low_byte <= '0;
      target_slave <= '0;
      target_register <= '0;
    end else begin
      phase <= phase_next;
      attempts_used <= attempts_used_next;
      silence_timer <= silence_timer_next;
      reply_crc <= reply_crc_next;
      reply_data <= reply_data_next;
      crc_low_byte <= crc_low_byte_next;
      target_slave <= target_slave_next;
      target_register <= target_register_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_timer: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (silence_timer == 16'd0))
    else $error("silence timer running while idle");
`endif

endmodule

[src/mbrm_emitter.sv]
// Result serializer: pending descriptor slot, request byte sequencing with running CRC.
module mbrm_emitter (
  input  logic clk,
  input  logic rst,
  input  logic desc_wr,
  input  mbrm_pkg::desc_t desc,
  output logic pend_full,
  mbrm_res_if.source res
);
  import mbrm_pkg::*;

  logic pend_valid;
  desc_t pend;
  logic cur_valid;
  desc_t cur;
  logic [2:0] idx;
  logic [15:0] crc;
  logic beat;
  logic load;
  logic [7:0] req_byte;

  always_comb begin
    case (idx)
      3'd0: req_byte = cur.slave;
      3'd1: req_byte = FUNC_READ_HOLDING;
      3'd2: req_byte = cur.register_addr[15:8];
      3'd3: req_byte = cur.register_addr[7:0];
      3'd4: req_byte = QUANTITY_ONE[15:8];
      3'd5: req_byte = QUANTITY_ONE[7:0];
      3'd6: req_byte = crc[7:0];
      3'd7: req_byte = crc[15:8];
      default: req_byte = 8'h00;
    endcase
  end

  assign res.valid = cur_valid;
  assign res.kind = cur.kind;
  assign res.tx_byte = (cur.kind == KIND_TX) ? req_byte : 8'h00;
  assign res.reading = (cur.kind == KIND_OK) ? cur.data : 16'h0000;
  assign res.last = (cur.kind != KIND_TX) || (idx == 3'd7);

  assign beat = res.valid && res.ready;
  assign load = pend_valid && (!cur_valid || (beat && res.last));
  assign pend_full = pend_valid && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (desc_wr) begin
        pend_valid <= 1'b1;
      end else if (load) begin
        pend_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (beat) begin
        if (res.last) begin
          cur_valid <= 1'b0;
          idx <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_wr) begin
      pend <= desc;
    end
    if (load) begin
      cur <= pend;
      crc <= CRC_INIT;
    end else if (beat && idx <= 3'd5) begin
      crc <= crc16_add(crc, req_byte);
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    desc_wr |-> (!pend_valid || load))
    else $error("descriptor written into a full slot");
  a_idx_only_tx: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0) |-> (cur_valid && cur.kind == KIND_TX))
    else $error("byte index advanced outside a request");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (beat && !res.last) |=> (cur_valid && idx == $past(idx) + 3'd1))
    else $error("request byte sequence broken");
`endif

endmodule

[src/modbus_read_register_master_top.sv]
// Top level of the Modbus RTU single holding register read master.
// Each command beat is accepted when the one-deep descriptor slot is free; byte and tick
// commands that cause no result never occupy it. A start or retry yields eight transmit
// beats (address, 0x03, register, count 1, CRC low, CRC high), one per cycle while
// res.ready holds, from the result serializer, which forms the request CRC a byte per
// beat; success and failure each yield one beat. A new command can be taken while the
// previous request is still going out. Registers: timeout_ticks at 0x0 and max_attempts
// at 0x4 on the APB port; the user must write them only while the engine is quiet, as
// the block itself does not enforce this.
module modbus_read_register_master_top (
  input  logic clk,
  input  logic rst,
  mbrm_cmd_if.sink cmd,
  mbrm_res_if.source res,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mbrm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mbrm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mbrm_pkg::APB_DATA_W-1:0] prdata,
  output logic pready
);
  import mbrm_pkg::*;

  logic [15:0] timeout_ticks;
  logic [3:0] max_attempts;
  logic cfg_wr;
  logic accept;
  logic pend_full;
  logic desc_wr;
  desc_t desc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_attempts <= MAX_ATTEMPTS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TIMEOUT) begin
        timeout_ticks <= pwdata[15:0];
      end else begin
        max_attempts <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_ATTEMPTS) begin
      prdata = {{(APB_DATA_W-4){1'b0}}, max_attempts};
    end else begin
      prdata = {{(APB_DATA_W-16){1'b0}}, timeout_ticks};
    end
  end

  assign cmd.ready = !pend_full;
  assign accept = cmd.valid && cmd.ready;

  mbrm_core u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .opcode           (cmd.opcode),
    .slave_address    (cmd.slave_address),
    .register_address (cmd.register_address),
    .rx_byte          (cmd.rx_byte),
    .timeout_ticks    (timeout_ticks),
    .max_attempts     (max_attempts),
    .desc_wr          (desc_wr),
    .desc             (desc)
  );

  mbrm_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .desc_wr   (desc_wr),
    .desc      (desc),
    .pend_full (pend_full),
    .res       (res)
  );

endmodule
